// ===== src/small_matrix_inverse_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the small matrix inverse core
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_CORE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_CORE_MACROS_SVH

// Same-cycle implication.
`define SMI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smi_pkg.sv =====
// ----------------------------------------------------------------------------
// Small matrix inverse package
// Widths, codes and the divider stage record shared by the core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smi_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;
    localparam int PROD_W = 32;
    localparam int ADJ_W  = 33;
    localparam int DET_W  = 49;
    localparam int DEN_W  = 48;
    localparam int REM_W  = 48;
    localparam int NUM_W  = 32;
    localparam int QBITS  = 32;
    localparam int NLANES = 9;
    localparam int DIM_W  = 2;

    localparam logic [DIM_W-1:0] DIM_2X2 = 2'd2;
    localparam logic [DIM_W-1:0] DIM_3X3 = 2'd3;

    typedef struct packed {
        logic                          valid;
        logic                          singular;
        logic [DEN_W-1:0]              den;
        logic [NLANES-1:0]             neg;
        logic [NLANES-1:0]             ovf;
        logic [NLANES-1:0][REM_W-1:0]  rem;
        logic [NLANES-1:0][QBITS-1:0]  quo;
    } t_div_st;

endpackage

`default_nettype wire

// ===== src/smi_mat_if.sv =====
// ----------------------------------------------------------------------------
// Matrix item channel
// Valid/ready channel carrying one 3x3 matrix of signed Q4.12 entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface smi_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

`default_nettype wire

// ===== src/smi_inv_if.sv =====
// ----------------------------------------------------------------------------
// Inverse item channel
// Valid/ready channel carrying one signed Q16.16 inverse and a singular flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface smi_inv_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic               singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, input ready);
    modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, output ready);
endinterface

`default_nettype wire

// ===== src/smi_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the dimension register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface smi_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/smi_adj.sv =====
// ----------------------------------------------------------------------------
// Adjugate and determinant front end
// Five stages: input capture, cofactor products, adjugate, determinant
// products, then determinant sum with the divider set-up for every lane.
// ----------------------------------------------------------------------------
`default_nettype none

module smi_adj
    import smi_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic                         i_dim2,
    input  wire logic [NLANES-1:0][IN_W-1:0]  i_mat,
    output t_div_st                           o_st
);

    localparam logic [3:0] MUL_L [18] = '{4'd4, 4'd7, 4'd2, 4'd1, 4'd1, 4'd2,
                                          4'd5, 4'd3, 4'd0, 4'd2, 4'd3, 4'd0,
                                          4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3};
    localparam logic [3:0] MUL_R [18] = '{4'd8, 4'd5, 4'd7, 4'd8, 4'd5, 4'd4,
                                          4'd6, 4'd8, 4'd8, 4'd6, 4'd2, 4'd5,
                                          4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1};

    logic                     r1_v, r2_v, r3_v, r4_v;
    logic                     r1_d2, r2_d2, r3_d2, r4_d2;
    logic signed [IN_W-1:0]   r1_a [NLANES];
    logic signed [PROD_W-1:0] r2_p [18];
    logic signed [IN_W-1:0]   r2_a [5];
    logic signed [ADJ_W-1:0]  r3_adj [NLANES];
    logic signed [ADJ_W-1:0]  r3_det2;
    logic signed [IN_W-1:0]   r3_a [3];
    logic signed [ADJ_W-1:0]  r4_adj [NLANES];
    logic signed [ADJ_W-1:0]  r4_det2;
    logic signed [DET_W-1:0]  r4_dp [3];
    t_div_st                  r_st;

    logic signed [ADJ_W-1:0]  n_adj [NLANES];
    logic signed [DET_W-1:0]  n_det;
    logic [DEN_W-1:0]         n_den;
    t_div_st                  n_st;
    logic [NUM_W-1:0]         n_num;
    logic [REM_W-1:0]         n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d2 <= i_dim2;
            r2_d2 <= r1_d2;
            r3_d2 <= r2_d2;
            r4_d2 <= r3_d2;
            for (int k = 0; k < NLANES; k++) begin
                r1_a[k] <= $signed(i_mat[k]);
            end
            for (int k = 0; k < 18; k++) begin
                r2_p[k] <= r1_a[MUL_L[k]] * r1_a[MUL_R[k]];
            end
            for (int k = 0; k < 5; k++) begin
                r2_a[k] <= r1_a[k];
            end
            r3_adj  <= n_adj;
            r3_det2 <= ADJ_W'(r2_p[16]) - ADJ_W'(r2_p[17]);
            for (int k = 0; k < 3; k++) begin
                r3_a[k] <= r2_a[k];
            end
            r4_adj  <= r3_adj;
            r4_det2 <= r3_det2;
            r4_dp[0] <= r3_a[0] * r3_adj[0];
            r4_dp[1] <= r3_a[1] * r3_adj[3];
            r4_dp[2] <= r3_a[2] * r3_adj[6];
        end
    end

    always_comb begin
        for (int k = 0; k < NLANES; k++) begin
            n_adj[k] = ADJ_W'(r2_p[2*k]) - ADJ_W'(r2_p[2*k+1]);
        end
        if (r2_d2) begin
            for (int k = 0; k < NLANES; k++) begin
                n_adj[k] = '0;
            end
            n_adj[0] = ADJ_W'(r2_a[4]);
            n_adj[1] = -ADJ_W'(r2_a[1]);
            n_adj[3] = -ADJ_W'(r2_a[3]);
            n_adj[4] = ADJ_W'(r2_a[0]);
        end
    end

    always_comb begin
        n_det = r4_d2 ? DET_W'(r4_det2) : (r4_dp[0] + r4_dp[1] + r4_dp[2]);
        n_den = n_det[DET_W-1] ? DEN_W'(-n_det) : DEN_W'(n_det);
        n_st.valid    = r4_v;
        n_st.singular = (n_det == '0);
        n_st.den      = n_den;
        for (int k = 0; k < NLANES; k++) begin
            n_num = r4_adj[k][ADJ_W-1] ? NUM_W'(-r4_adj[k]) : NUM_W'(r4_adj[k]);
            n_hi  = REM_W'(n_num[NUM_W-1:4]);
            n_st.neg[k] = r4_adj[k][ADJ_W-1] ^ n_det[DET_W-1];
            n_st.ovf[k] = (n_hi >= n_den);
            n_st.rem[k] = n_st.ovf[k] ? '0 : n_hi;
            n_st.quo[k] = {n_num[3:0], 28'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st.singular <= n_st.singular;
            r_st.den      <= n_st.den;
            r_st.neg      <= n_st.neg;
            r_st.ovf      <= n_st.ovf;
            r_st.rem      <= n_st.rem;
            r_st.quo      <= n_st.quo;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

// ===== src/smi_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for all nine lanes: develops one quotient bit per lane
// against the shared determinant magnitude and hands the record on.
// ----------------------------------------------------------------------------
`default_nettype none

module smi_div_cell
    import smi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_div_st i_st,
    output t_div_st      o_st
);

    t_div_st          r_st;
    t_div_st          n_st;
    logic [REM_W:0]   n_try;
    logic [REM_W:0]   n_diff;
    logic             n_ge;

    always_comb begin
        n_st = i_st;
        for (int k = 0; k < NLANES; k++) begin
            n_try  = {i_st.rem[k], i_st.quo[k][QBITS-1]};
            n_diff = n_try - {1'b0, i_st.den};
            n_ge   = (n_try >= {1'b0, i_st.den});
            n_st.rem[k] = n_ge ? n_diff[REM_W-1:0] : n_try[REM_W-1:0];
            n_st.quo[k] = {i_st.quo[k][QBITS-2:0], n_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st.singular <= n_st.singular;
            r_st.den      <= n_st.den;
            r_st.neg      <= n_st.neg;
            r_st.ovf      <= n_st.ovf;
            r_st.rem      <= n_st.rem;
            r_st.quo      <= n_st.quo;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

// ===== src/small_matrix_inverse_core.sv =====
// ----------------------------------------------------------------------------
// Small matrix inverse core
// Inverts a 2x2 or 3x3 signed Q4.12 matrix into signed Q16.16 by adjugate
// and determinant, with a chain of divider cells for the nine quotients.
// ----------------------------------------------------------------------------
// Channel   Direction  Item
// i_mat     in         nine Q4.12 entries, row-major
// o_inv     out        nine Q16.16 entries and the singular flag
// i_cfg     in         dimension register write (2 selects 2x2)
//
// One item is accepted per cycle while the output is not stalled; each item
// passes through five front stages, a chain of 32 divider cells and the
// output register.
// The whole pipeline advances together and holds while the output is full
// and not taken. Reset is synchronous and clears the valid bits and sets
// the dimension to 3x3.
// ----------------------------------------------------------------------------
`default_nettype none

`include "small_matrix_inverse_core_macros.svh"

module small_matrix_inverse_core
    import smi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smi_mat_if.sink   i_mat,
    smi_inv_if.source o_inv,
    smi_cfg_if.sink   i_cfg
);

    logic [DIM_W-1:0]             r_dim;
    logic                         w_en;
    logic [NLANES-1:0][IN_W-1:0]  w_mat;
    t_div_st                      w_st [QBITS+1];
    logic                         r_out_valid;
    logic                         r_sing;
    logic [OUT_W-1:0]             r_inv [NLANES];
    logic [OUT_W-1:0]             n_inv [NLANES];
    logic [QBITS-1:0]             n_q;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_3X3;
        end else if (i_cfg.valid) begin
            r_dim <= i_cfg.data;
        end
    end

    assign w_en        = !r_out_valid || o_inv.ready;
    assign i_mat.ready = w_en;
    assign w_mat = {i_mat.m22, i_mat.m21, i_mat.m20, i_mat.m12, i_mat.m11,
                    i_mat.m10, i_mat.m02, i_mat.m01, i_mat.m00};

    smi_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_mat.valid),
        .i_dim2  (r_dim == DIM_2X2),
        .i_mat   (w_mat),
        .o_st    (w_st[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        smi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_st    (w_st[g]),
            .o_st    (w_st[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < NLANES; k++) begin
            n_q = w_st[QBITS].quo[k];
            if (w_st[QBITS].singular) begin
                n_inv[k] = '0;
            end else if (w_st[QBITS].neg[k]) begin
                n_inv[k] = (w_st[QBITS].ovf[k] || (n_q[QBITS-1] && (|n_q[QBITS-2:0])))
                           ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-n_q);
            end else begin
                n_inv[k] = (w_st[QBITS].ovf[k] || n_q[QBITS-1])
                           ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(n_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_st[QBITS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sing <= w_st[QBITS].singular;
            r_inv  <= n_inv;
        end
    end

    assign o_inv.valid    = r_out_valid;
    assign o_inv.singular = r_sing;
    assign o_inv.inv00    = r_inv[0];
    assign o_inv.inv01    = r_inv[1];
    assign o_inv.inv02    = r_inv[2];
    assign o_inv.inv10    = r_inv[3];
    assign o_inv.inv11    = r_inv[4];
    assign o_inv.inv12    = r_inv[5];
    assign o_inv.inv20    = r_inv[6];
    assign o_inv.inv21    = r_inv[7];
    assign o_inv.inv22    = r_inv[8];

    `SMI_ASSERT_SAME(a_sing_zero, i_clk, i_rst_n, o_inv.valid && o_inv.singular,
        o_inv.inv00 == '0 && o_inv.inv11 == '0 && o_inv.inv22 == '0,
        "Singular item carries a nonzero entry.")
    `SMI_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n,
        w_st[QBITS].valid && !w_st[QBITS].singular && !w_st[QBITS].ovf[0],
        w_st[QBITS].rem[0] < w_st[QBITS].den,
        "Divider remainder not below the determinant.")
    `SMI_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, !w_en,
        o_inv.valid && $stable(o_inv.inv00) && $stable(w_st[QBITS].quo),
        "Pipeline moved while the output was stalled.")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Small matrix inverse core testbench
// Streams 2x2 and 3x3 Q4.12 matrices through the core with random gaps on
// both channels, predicts each Q16.16 inverse and singular flag, and checks
// the results in order. The dimension register is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import smi_pkg::*;
();

    localparam int LATENCY   = 38;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } t_mat;

    typedef struct packed {
        logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
        logic               singular;
    } t_inv;

    logic i_clk;
    logic i_rst_n;
    smi_mat_if mat_ch ();
    smi_inv_if inv_ch ();
    smi_cfg_if cfg_ch ();

    small_matrix_inverse_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_inv  (inv_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    t_mat       pending_mats[$];
    t_inv       expected_invs[$];
    logic [1:0] dim_now;
    int         error_count;
    int         cycle_count;
    bit         idle_on;
    bit         send_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [31:0] scaled_quotient(longint num, longint den);
        bit       neg;
        longint   n;
        longint   d;
        longint   q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n <<< 28) / d;
        if (num == 0) return 32'sd0;
        if (neg) begin
            if (q > 64'sd2147483648) return 32'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'sd2147483647) return 32'h7fff_ffff;
        return 32'(q);
    endfunction

    function automatic t_inv invert_matrix(t_mat m, logic [1:0] dim);
        longint a[9];
        longint adj[9];
        longint det;
        logic signed [31:0] q[9];
        t_inv r;
        a = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
        foreach (adj[i]) adj[i] = 0;
        if (dim == DIM_2X2) begin
            adj[0] = a[4];
            adj[1] = -a[1];
            adj[3] = -a[3];
            adj[4] = a[0];
            det = a[0] * a[4] - a[1] * a[3];
        end else begin
            adj[0] = a[4] * a[8] - a[7] * a[5];
            adj[1] = a[2] * a[7] - a[1] * a[8];
            adj[2] = a[1] * a[5] - a[2] * a[4];
            adj[3] = a[5] * a[6] - a[3] * a[8];
            adj[4] = a[0] * a[8] - a[2] * a[6];
            adj[5] = a[3] * a[2] - a[0] * a[5];
            adj[6] = a[3] * a[7] - a[6] * a[4];
            adj[7] = a[6] * a[1] - a[0] * a[7];
            adj[8] = a[0] * a[4] - a[3] * a[1];
            det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        end
        foreach (q[i]) q[i] = (det == 0) ? 32'sd0 : scaled_quotient(adj[i], det);
        r = '{q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8], det == 0};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("Mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_ch.valid <= 1'b0;
        end else if (mat_ch.valid && !mat_ch.ready) begin
        end else if (pending_mats.size() > 0 && !send_hold
                     && !(idle_on && $urandom_range(99) < 18)) begin
            {mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11, mat_ch.m12,
             mat_ch.m20, mat_ch.m21, mat_ch.m22} <= pending_mats[0];
            expected_invs.push_back(invert_matrix(pending_mats.pop_front(), dim_now));
            mat_ch.valid <= 1'b1;
        end else begin
            mat_ch.valid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_inv got;
        t_inv want;
        if (!i_rst_n) begin
            inv_ch.ready <= 1'b0;
        end else begin
            if (inv_ch.valid && inv_ch.ready) begin
                got = '{inv_ch.inv00, inv_ch.inv01, inv_ch.inv02, inv_ch.inv10,
                        inv_ch.inv11, inv_ch.inv12, inv_ch.inv20, inv_ch.inv21,
                        inv_ch.inv22, inv_ch.singular};
                if (expected_invs.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    want = expected_invs.pop_front();
                    if (got.inv00 !== want.inv00) report_mismatch("inv00", got.inv00, want.inv00);
                    if (got.inv01 !== want.inv01) report_mismatch("inv01", got.inv01, want.inv01);
                    if (got.inv02 !== want.inv02) report_mismatch("inv02", got.inv02, want.inv02);
                    if (got.inv10 !== want.inv10) report_mismatch("inv10", got.inv10, want.inv10);
                    if (got.inv11 !== want.inv11) report_mismatch("inv11", got.inv11, want.inv11);
                    if (got.inv12 !== want.inv12) report_mismatch("inv12", got.inv12, want.inv12);
                    if (got.inv20 !== want.inv20) report_mismatch("inv20", got.inv20, want.inv20);
                    if (got.inv21 !== want.inv21) report_mismatch("inv21", got.inv21, want.inv21);
                    if (got.inv22 !== want.inv22) report_mismatch("inv22", got.inv22, want.inv22);
                    if (got.singular !== want.singular)
                        report_mismatch("singular", got.singular, want.singular);
                end
            end
            inv_ch.ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    function automatic logic signed [15:0] random_entry();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh1000;
            3: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_mat random_matrix();
        t_mat m;
        m = '{random_entry(), random_entry(), random_entry(), random_entry(), random_entry(),
              random_entry(), random_entry(), random_entry(), random_entry()};
        if ($urandom_range(9) == 0) begin
            m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
        end
        return m;
    endfunction

    task automatic drain_and_wait();
        while (pending_mats.size() > 0 || mat_ch.valid || expected_invs.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_dimension(logic [1:0] value);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        dim_now = value;
    endtask

    task automatic load_directed();
        pending_mats.push_back('{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000});
        pending_mats.push_back('0);
        pending_mats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                                 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        pending_mats.push_back('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000});
        pending_mats.push_back('{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001});
        pending_mats.push_back('{16'sh0001, 16'sh0001, 16'sh7fff, 0, 16'shffff,
                                 16'sh8000, 16'sh1234, 16'sh7fff, 16'sh0001});
        pending_mats.push_back('{16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
                                 16'shffff, 16'shffff, 16'shffff, 16'shffff});
        pending_mats.push_back('{16'sh2000, 16'sh1000, 16'sh7fff, 16'sh1000, 16'sh0800,
                                 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh0001});
    endtask

    initial begin
        logic [1:0] dims[6];
        dims = '{DIM_2X2, DIM_3X3, 2'd0, DIM_2X2, 2'd1, DIM_3X3};
        error_count  = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        send_hold    = 1'b0;
        dim_now      = DIM_3X3;
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = DIM_3X3;
        mat_ch.valid = 1'b0;
        {mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11, mat_ch.m12,
         mat_ch.m20, mat_ch.m21, mat_ch.m22} = '0;
        inv_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_directed();
        drain_and_wait();
        foreach (dims[p]) begin
            write_dimension(dims[p]);
            if (p < 2) load_directed();
            idle_on = (p != 3);
            for (int k = 0; k < 240; k++) pending_mats.push_back(random_matrix());
            if (p == 4) begin
                while (pending_mats.size() > 120) @(posedge i_clk);
                send_hold = 1'b1;
                while (mat_ch.valid || expected_invs.size() > 0) @(posedge i_clk);
                send_hold = 1'b0;
            end
            drain_and_wait();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
